>>> src/utrs_pkg.sv
// Shared types and constants for the serial transmitter/receiver core.
// No dependencies; every other file in src imports this package.
package utrs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    // Configuration register indexes
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_LONG   = 1'b1;

    localparam int PERIOD_W = 15;
    localparam int DATA_W   = 10;

    // Status word bit positions
    localparam int ST_OVERRUN = 15;
    localparam int ST_RBF     = 14;
    localparam int ST_TBE     = 13;
    localparam int ST_TSRE    = 12;
    localparam int ST_RXD     = 11;

    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] write_data;
        logic        rxd_level;
        logic        rbf_pending;
        logic        break_force;
    } in_word_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        txd_line;
        logic        tbe_irq;
        logic        rbf_irq;
    } out_word_t;

    // Transmitter view after the current tick
    typedef struct packed {
        logic line_bit;
        logic tbe_irq;
        logic holding_empty;
        logic shifter_empty;
    } tx_status_t;

    // Receiver view after the current tick
    typedef struct packed {
        logic              rbf_irq;
        logic              overrun;
        logic [DATA_W-1:0] holding;
    } rx_status_t;

endpackage

>>> src/utrs_tx.sv
// Transmit half: holding buffer, shift register and bit timer.
// Depends on utrs_pkg.
module utrs_tx
    import utrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                wr_en,
    input  logic [DATA_W-1:0]   wr_data,
    input  logic [PERIOD_W-1:0] period,
    output tx_status_t          status
);

    logic [DATA_W-1:0]   holding_reg, holding_next;
    logic [DATA_W:0]     shifter_reg, shifter_next;
    logic [PERIOD_W-1:0] timer_reg, timer_next;
    logic                line_reg, line_next;
    logic                tbe;

    // Compute one tick: pending bit first, then the bus write
    always_comb
    begin
        holding_next = holding_reg;
        shifter_next = shifter_reg;
        timer_next   = timer_reg;
        line_next    = line_reg;
        tbe          = 1'b0;

        if (shifter_reg != '0)
        begin
            if (timer_reg == '0)
            begin
                line_next    = shifter_reg[0];
                shifter_next = shifter_reg >> 1;
                if (shifter_next != '0)
                begin
                    timer_next = period;
                end
                else if (holding_reg != '0)
                begin
                    // refill from the buffer with a start bit in front
                    shifter_next = {holding_reg, 1'b0};
                    holding_next = '0;
                    tbe          = 1'b1;
                    timer_next   = period;
                end
            end
            else
            begin
                timer_next = timer_reg - PERIOD_W'(1);
            end
        end

        if (wr_en)
        begin
            holding_next = wr_data;
            if (shifter_next == '0 && wr_data != '0)
            begin
                // load and drive the start bit in the same tick
                shifter_next = {1'b0, wr_data};
                holding_next = '0;
                line_next    = 1'b0;
                tbe          = 1'b1;
                timer_next   = period;
            end
        end
    end

    // Hold state between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= '0;
            shifter_reg <= '0;
            timer_reg   <= '0;
            line_reg    <= 1'b1;
        end
        else if (step)
        begin
            holding_reg <= holding_next;
            shifter_reg <= shifter_next;
            timer_reg   <= timer_next;
            line_reg    <= line_next;
        end
    end

    assign status.line_bit      = line_next;
    assign status.tbe_irq       = tbe;
    assign status.holding_empty = (holding_next == '0);
    assign status.shifter_empty = (shifter_next == '0);

endmodule

>>> src/utrs_rx.sv
// Receive half: edge detect, sample timer, shift register, buffer, overrun.
// Depends on utrs_pkg.
module utrs_rx
    import utrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                rxd,
    input  logic                pend,
    input  logic                rd_en,
    input  logic [PERIOD_W-1:0] period,
    input  logic                long_mode,
    output rx_status_t          status
);

    logic [DATA_W:0]     shifter_reg, shifter_next;
    logic [DATA_W-1:0]   holding_reg, holding_next;
    logic [3:0]          count_reg, count_next;
    logic [15:0]         timer_reg, timer_next;
    logic                busy_reg, busy_next;
    logic                overrun_reg, overrun_next;
    logic                last_reg, last_next;
    logic                rbf;
    logic [3:0]          total;
    logic [15:0]         period_plus;
    logic [17:0]         period_x3;
    logic [16:0]         first_delay;

    // First sample lands one and a half periods after the edge
    assign period_plus = {1'b0, period} + 16'd1;
    assign period_x3   = {2'b00, period_plus} + {1'b0, period_plus, 1'b0};
    assign first_delay = period_x3[17:1] - 17'd1;
    assign total       = long_mode ? 4'd11 : 4'd10;

    // Compute one tick: pending sample, bus read, then edge detect
    always_comb
    begin
        shifter_next = shifter_reg;
        holding_next = holding_reg;
        count_next   = count_reg;
        timer_next   = timer_reg;
        busy_next    = busy_reg;
        overrun_next = overrun_reg;
        rbf          = 1'b0;

        if (busy_reg)
        begin
            if (timer_reg == '0)
            begin
                if (count_reg < 4'd11)
                begin
                    shifter_next[count_reg] = rxd;
                end
                count_next = count_reg + 4'd1;
                timer_next = {1'b0, period};
                if (count_next >= total)
                begin
                    holding_next = shifter_next[DATA_W-1:0];
                    shifter_next = '0;
                    overrun_next = pend;
                    rbf          = 1'b1;
                    if (rxd)
                    begin
                        busy_next  = 1'b0;
                        timer_next = timer_reg;
                    end
                    else
                    begin
                        // stop bit low: begin the next packet at once
                        count_next = '0;
                    end
                end
            end
            else
            begin
                timer_next = timer_reg - 16'd1;
            end
        end

        if (rd_en && !pend)
        begin
            overrun_next = 1'b0;
        end

        if (last_reg && !rxd && !busy_next)
        begin
            count_next = '0;
            busy_next  = 1'b1;
            timer_next = first_delay[15:0];
        end
        last_next = rxd;
    end

    // Hold state between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shifter_reg <= '0;
            holding_reg <= '0;
            count_reg   <= '0;
            timer_reg   <= '0;
            busy_reg    <= 1'b0;
            overrun_reg <= 1'b0;
            last_reg    <= 1'b1;
        end
        else if (step)
        begin
            shifter_reg <= shifter_next;
            holding_reg <= holding_next;
            count_reg   <= count_next;
            timer_reg   <= timer_next;
            busy_reg    <= busy_next;
            overrun_reg <= overrun_next;
            last_reg    <= last_next;
        end
    end

    assign status.rbf_irq = rbf;
    assign status.overrun = overrun_next;
    assign status.holding = holding_next;

endmodule

>>> src/uart_tx_rx_with_status_core.sv
// Top level of the serial transmitter/receiver with status word.
// Depends on utrs_pkg, utrs_tx and utrs_rx.
//
//   port group   direction  handshake         payload
//   in_*         in         in_valid/in_ready  in_word   (in_word_t)
//   out_*        out        out_valid/out_ready out_word (out_word_t)
//   cfg_*        in         cfg_we             cfg_index, cfg_data
//
// Each accepted word is one tick of the bit timers; one word per cycle while
// the output is not stalled. The result sits in the output register the
// cycle after acceptance. in_ready is high whenever the output register is
// empty or being drained, so a stalled output only blocks when it is full.
// Reset clears all state but the output word register; the transmit line and edge detector start high.
module uart_tx_rx_with_status_core
    import utrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_word,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data
);

    logic [PERIOD_W-1:0] period_reg;
    logic                long_mode_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg, out_word_next;
    logic                accept;
    tx_status_t          tx_stat;
    rx_status_t          rx_stat;
    logic                is_read;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_read  = (in_word.opcode == OP_READ);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= '0;
            long_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD: period_reg    <= cfg_data;
                REG_LONG:   long_mode_reg <= cfg_data[0];
                default:    period_reg    <= period_reg;
            endcase
        end
    end

    utrs_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .wr_en   (in_word.opcode == OP_WRITE),
        .wr_data (in_word.write_data[DATA_W-1:0]),
        .period  (period_reg),
        .status  (tx_stat)
    );

    utrs_rx u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .rxd       (in_word.rxd_level),
        .pend      (in_word.rbf_pending),
        .rd_en     (is_read),
        .period    (period_reg),
        .long_mode (long_mode_reg),
        .status    (rx_stat)
    );

    // Assemble the result word
    always_comb
    begin
        out_word_next = '0;
        if (is_read)
        begin
            out_word_next.read_data[DATA_W-1:0] = rx_stat.holding;
            out_word_next.read_data[ST_OVERRUN] = rx_stat.overrun;
            out_word_next.read_data[ST_RBF]     = in_word.rbf_pending;
            out_word_next.read_data[ST_TBE]     = tx_stat.holding_empty;
            out_word_next.read_data[ST_TSRE]    = tx_stat.shifter_empty;
            out_word_next.read_data[ST_RXD]     = in_word.rxd_level;
        end
        out_word_next.txd_line = tx_stat.line_bit && !in_word.break_force;
        out_word_next.tbe_irq  = tx_stat.tbe_irq;
        out_word_next.rbf_irq  = rx_stat.rbf_irq;
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A full, stalled output register must block new words
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("word accepted while output register stalled");

    // A buffer transfer shows up as a TBE pulse on the next result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tx_stat.tbe_irq) |=> (out_valid && out_word.tbe_irq))
        else $error("TBE pulse lost");

    // Only a read returns a status word
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_read) |=> (out_word.read_data == '0))
        else $error("status word on a non-read");

endmodule
